### src/cfa_pkg.sv
// Package: types, opcodes and helpers for the constant-folding ALU.
package cfa_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned FuncW = 5;
	localparam int unsigned QueueDepthDefault = 4;
	localparam int unsigned DivStages = 64;

	typedef enum logic [FuncW-1:0] {
		FN_ADD = 5'd0, FN_SUB = 5'd1, FN_MUL = 5'd2, FN_DIV = 5'd3, FN_MOD = 5'd4,
		FN_AND = 5'd5, FN_OR = 5'd6, FN_XOR = 5'd7, FN_SHL = 5'd8, FN_SHR = 5'd9,
		FN_LT = 5'd10, FN_GT = 5'd11, FN_LE = 5'd12, FN_GE = 5'd13, FN_EQ = 5'd14,
		FN_NE = 5'd15, FN_NEG = 5'd16, FN_NOT = 5'd17, FN_LNOT = 5'd18,
		FN_PLUS = 5'd19
	} func_t;

	typedef struct packed {
		logic [FuncW-1:0] func;
		logic signed [DataW-1:0] operand_a;
		logic signed [DataW-1:0] operand_b;
		logic wrap_32;
	} in_item_t;

	typedef struct packed {
		logic signed [DataW-1:0] result;
		logic ok;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic is_div;
		logic is_mod;
		logic is_mul;
		logic fail;
		logic wrap;
		logic neg_q;
		logic neg_r;
		logic [DataW-1:0] mag_a;
		logic [DataW-1:0] mag_b;
		logic [DataW-1:0] value;
	} cls_t;

	function automatic logic [DataW-1:0] to_s32(input logic [DataW-1:0] v);
		return {{(DataW-32){v[31]}}, v[31:0]};
	endfunction

endpackage

### src/cfa_front.sv
// Front end: accepts items, evaluates the simple operations, prepares divide/multiply.
module cfa_front (
	input  logic clk,
	input  logic arst_n,
	input  cfa_pkg::in_item_t in_item,
	input  logic in_valid,
	output logic in_ready,
	output cfa_pkg::cls_t cls,
	output logic cls_valid,
	input  logic cls_ready
);
	import cfa_pkg::*;

	logic [DataW-1:0] a, b, r, ma, mb;
	logic w, fit, ok, slt_ab, slt_ba, dv, md, ml;
	logic [5:0] sh;
	logic [31:0] s32;
	cls_t c;

	assign a = in_item.operand_a;
	assign b = in_item.operand_b;
	assign w = in_item.wrap_32;
	assign slt_ab = $signed(a) < $signed(b);
	assign slt_ba = $signed(b) < $signed(a);
	assign sh = w ? {1'b0, b[4:0]} : b[5:0];
	assign ma = a[DataW-1] ? (~a + 1'b1) : a;
	assign mb = b[DataW-1] ? (~b + 1'b1) : b;
	assign s32 = a[31:0] << b[4:0];

	always_comb begin
		r = '0;
		ok = 1'b1;
		fit = 1'b1;
		dv = 1'b0;
		md = 1'b0;
		ml = 1'b0;
		case (in_item.func)
			FN_ADD: r = a + b;
			FN_SUB: r = a - b;
			FN_MUL: ml = 1'b1;
			FN_DIV: dv = 1'b1;
			FN_MOD: md = 1'b1;
			FN_AND: r = a & b;
			FN_OR: r = a | b;
			FN_XOR: r = a ^ b;
			FN_SHL: begin
				r = w ? to_s32({32'b0, s32}) : (a << sh);
				fit = 1'b0;
			end
			FN_SHR: begin
				r = w ? DataW'($signed(to_s32(a)) >>> sh) : DataW'($signed(a) >>> sh);
				fit = 1'b0;
			end
			FN_LT: begin r = {63'b0, slt_ab}; fit = 1'b0; end
			FN_GT: begin r = {63'b0, slt_ba}; fit = 1'b0; end
			FN_LE: begin r = {63'b0, !slt_ba}; fit = 1'b0; end
			FN_GE: begin r = {63'b0, !slt_ab}; fit = 1'b0; end
			FN_EQ: begin r = {63'b0, a == b}; fit = 1'b0; end
			FN_NE: begin r = {63'b0, a != b}; fit = 1'b0; end
			FN_NEG: r = ~a + 1'b1;
			FN_NOT: r = ~a;
			FN_LNOT: begin r = {63'b0, a == '0}; fit = 1'b0; end
			FN_PLUS: begin r = a; fit = 1'b0; end
			default: ok = 1'b0;
		endcase
		if ((dv || md) && (b == '0 || (b == '1 &&
				(a == {1'b1, 63'b0} || (w && a == 64'hFFFF_FFFF_8000_0000)))))
			ok = 1'b0;
		if (!ok)
			r = '0;
		else if (w && fit)
			r = to_s32(r);
		c.is_div = dv;
		c.is_mod = md;
		c.is_mul = ml;
		c.fail = !ok;
		c.wrap = w;
		c.neg_q = a[DataW-1] ^ b[DataW-1];
		c.neg_r = a[DataW-1];
		c.mag_a = ml ? a : ma;
		c.mag_b = ml ? b : mb;
		c.value = r;
	end

	// output register with handshake
	cls_t cls_q;
	logic vld_q;
	assign in_ready = !vld_q || cls_ready;
	assign cls = cls_q;
	assign cls_valid = vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cls_q <= c;
		end
	end
endmodule

### src/cfa_queue.sv
// Small FIFO between the front and back ends.
module cfa_queue #(
	parameter int unsigned Depth = cfa_pkg::QueueDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  cfa_pkg::cls_t wr_data,
	input  logic wr_valid,
	output logic wr_ready,
	output cfa_pkg::cls_t rd_data,
	output logic rd_valid,
	input  logic rd_ready
);
	import cfa_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	cls_t mem_q [Depth];
	logic [PtrW-1:0] wp_q, rp_q;
	logic [PtrW:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != (PtrW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end
endmodule

### src/cfa_back.sv
// Back end: pipelined divider (one quotient bit per stage) and split multiplier.
module cfa_back (
	input  logic clk,
	input  logic arst_n,
	input  cfa_pkg::cls_t cls,
	input  logic cls_valid,
	output logic cls_ready,
	output cfa_pkg::out_item_t out_item,
	output logic out_valid,
	input  logic out_ready
);
	import cfa_pkg::*;

	localparam int unsigned N = DivStages;

	// pipeline advances as one when the final slot is free
	logic adv;
	cls_t st_q [N+1];
	logic [DataW-1:0] rem_q [N+1];
	logic [DataW-1:0] quo_q [N+1];
	logic v_q [N+1];
	logic [DataW-1:0] pp_s1 [4];
	out_item_t o_q;
	logic ov_q;

	assign adv = !ov_q || out_ready;
	assign cls_ready = adv;
	assign out_item = o_q;
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) v_q[i] <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_q[0] <= cls_valid;
			for (int i = 1; i <= N; i++) v_q[i] <= v_q[i-1];
			ov_q <= v_q[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0] <= cls;
			rem_q[0] <= '0;
			quo_q[0] <= cls.mag_a;
			for (int i = 1; i <= N; i++) begin
				logic [DataW:0] tr;
				logic [DataW:0] df;
				st_q[i] <= st_q[i-1];
				tr = {rem_q[i-1], quo_q[i-1][DataW-1]};
				df = tr - {1'b0, st_q[i-1].mag_b};
				if (!df[DataW]) begin
					rem_q[i] <= df[DataW-1:0];
					quo_q[i] <= {quo_q[i-1][DataW-2:0], 1'b1};
				end else begin
					rem_q[i] <= tr[DataW-1:0];
					quo_q[i] <= {quo_q[i-1][DataW-2:0], 1'b0};
				end
			end
			// 32x32 partial products, low 64 bits, in the last stage
			pp_s1[0] <= st_q[N-1].mag_a[31:0] * st_q[N-1].mag_b[31:0];
			pp_s1[1] <= {st_q[N-1].mag_a[63:32] * st_q[N-1].mag_b[31:0], 32'b0};
			pp_s1[2] <= {st_q[N-1].mag_a[31:0] * st_q[N-1].mag_b[63:32], 32'b0};
			pp_s1[3] <= '0;
			begin
				logic [DataW-1:0] r;
				r = st_q[N].value;
				if (st_q[N].is_div)
					r = st_q[N].neg_q ? (~quo_q[N] + 1'b1) : quo_q[N];
				else if (st_q[N].is_mod)
					r = st_q[N].neg_r ? (~rem_q[N] + 1'b1) : rem_q[N];
				else if (st_q[N].is_mul)
					r = pp_s1[0] + pp_s1[1] + pp_s1[2] + pp_s1[3];
				if ((st_q[N].is_div || st_q[N].is_mod || st_q[N].is_mul) && st_q[N].wrap)
					r = to_s32(r);
				if (st_q[N].fail) r = '0;
				o_q.result <= r;
				o_q.ok <= !st_q[N].fail;
			end
		end
	end
endmodule

### src/constant_fold_alu.sv
// Top level of the constant-folding integer ALU.
// Usage:
//   in channel (in_valid/in_ready, in_item): one operation per item with
//   func, operand_a, operand_b and wrap_32.
//   out channel (out_valid/out_ready, out_item): result and ok, one per item,
//   in input order.
// Path: the front register, the queue, then 64 divider stages plus an
//   output register.
// Throughput: one item per cycle unless out_ready stalls; all operations
//   share the fixed-length back pipeline, one restoring-divide bit per stage.
// The queue (QueueDepth entries) lets the front keep accepting while the back
//   pipeline is held.
// Reset: all valid flags and queue pointers clear; no item is in flight.
// Receiver stall: the back pipeline holds in place, the queue fills, then
//   in_ready drops.
module constant_fold_alu #(
	parameter int unsigned QueueDepth = cfa_pkg::QueueDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  cfa_pkg::in_item_t in_item,
	input  logic in_valid,
	output logic in_ready,
	output cfa_pkg::out_item_t out_item,
	output logic out_valid,
	input  logic out_ready
);
	import cfa_pkg::*;

	cls_t f_cls, q_cls;
	logic f_vld, f_rdy, q_vld, q_rdy;

	cfa_front u_front (
		.clk, .arst_n, .in_item, .in_valid, .in_ready,
		.cls(f_cls), .cls_valid(f_vld), .cls_ready(f_rdy)
	);
	cfa_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .wr_data(f_cls), .wr_valid(f_vld), .wr_ready(f_rdy),
		.rd_data(q_cls), .rd_valid(q_vld), .rd_ready(q_rdy)
	);
	cfa_back u_back (
		.clk, .arst_n, .cls(q_cls), .cls_valid(q_vld), .cls_ready(q_rdy),
		.out_item, .out_valid, .out_ready
	);
endmodule
